### rtl/spiking_neuron_step_assert.svh
// ----------------------------------------------------------------------------
// Spiking neuron step assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPIKING_NEURON_STEP_ASSERT_SVH
`define SPIKING_NEURON_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define SNSTEP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spiking neuron step: implication check failed");
`define SNSTEP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiking neuron step: next-cycle check failed");
`else
`define SNSTEP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SNSTEP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/snstep_pkg.sv
// ----------------------------------------------------------------------------
// Spiking neuron step package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package snstep_pkg;

  localparam int Q_W       = 24;
  localparam int TH_W      = 23;
  localparam int BETA_W    = 16;
  localparam int ID_W      = 8;
  localparam int ID_COUNT  = 2 ** ID_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NEURON_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_POTENTIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_JUMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR     = 3'd4;

  localparam logic KIND_IZHIKEVICH = 1'b0;
  localparam logic KIND_LIF        = 1'b1;

  localparam int RST_THRESHOLD = 45875;
  localparam int RST_RESET_POT = 6881;
  localparam int RST_JUMP      = 27001;
  localparam int RST_LEAK      = 62259;

  localparam int COEF_A2 = -13763;
  localparam int COEF_A3 = -1245;
  localparam int Q_MAX   = 8388607;
  localparam int Q_MIN   = -8388608;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic              kind;
    logic [TH_W-1:0]   threshold;
    q_t                reset_potential;
    q_t                recovery_jump;
    logic [BETA_W-1:0] leak_factor;
  } cfg_t;

  typedef struct packed {
    logic            spike;
    logic [ID_W-1:0] neuron_id;
  } res_t;

  typedef struct packed {
    logic       hazard;
    logic [1:0] inflight;
  } core_status_t;

endpackage

### rtl/snstep_in_if.sv
// ----------------------------------------------------------------------------
// Spiking neuron step input channel
// Valid/ready channel carrying one neuron update request per item.
// ----------------------------------------------------------------------------
interface snstep_in_if;
  logic                               valid;
  logic                               ready;
  logic [snstep_pkg::ID_W-1:0]        neuron_index;
  logic signed [snstep_pkg::Q_W-1:0]  input_current;
  logic                               first_step;

  modport source (output valid, neuron_index, input_current, first_step, input ready);
  modport sink (input valid, neuron_index, input_current, first_step, output ready);
endinterface

### rtl/snstep_out_if.sv
// ----------------------------------------------------------------------------
// Spiking neuron step result channel
// Valid/ready channel carrying the spike flag and neuron id of each item.
// ----------------------------------------------------------------------------
interface snstep_out_if;
  logic                        valid;
  logic                        ready;
  logic                        spike;
  logic [snstep_pkg::ID_W-1:0] neuron_id;

  modport source (output valid, spike, neuron_id, input ready);
  modport sink (input valid, spike, neuron_id, output ready);
endinterface

### rtl/snstep_cfg_if.sv
// ----------------------------------------------------------------------------
// Spiking neuron step configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface snstep_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [snstep_pkg::CFG_IDX_W-1:0] index;
  logic [snstep_pkg::Q_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/snstep_cfg_regs.sv
// ----------------------------------------------------------------------------
// Spiking neuron step configuration registers
// Holds the neuron kind, threshold, reset potential, jump and leak factor.
// ----------------------------------------------------------------------------
module snstep_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  snstep_cfg_if.sink         cfg,
  output snstep_pkg::cfg_t   regs
);
  import snstep_pkg::*;

  logic wr;

  assign cfg.ready = !rst;
  assign wr = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kind            <= KIND_IZHIKEVICH;
      regs.threshold       <= TH_W'(RST_THRESHOLD);
      regs.reset_potential <= Q_W'(RST_RESET_POT);
      regs.recovery_jump   <= Q_W'(RST_JUMP);
      regs.leak_factor     <= BETA_W'(RST_LEAK);
    end else if (wr) begin
      case (cfg.index)
        CFG_NEURON_KIND:     regs.kind            <= cfg.data[0];
        CFG_FIRE_THRESHOLD:  regs.threshold       <= cfg.data[TH_W-1:0];
        CFG_RESET_POTENTIAL: regs.reset_potential <= cfg.data;
        CFG_RECOVERY_JUMP:   regs.recovery_jump   <= cfg.data;
        CFG_LEAK_FACTOR:     regs.leak_factor     <= cfg.data[BETA_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/snstep_core.sv
// ----------------------------------------------------------------------------
// Spiking neuron step core
// State memories and the three-stage membrane and recovery update pipeline.
// ----------------------------------------------------------------------------
module snstep_core #(
  parameter int NEURONS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [snstep_pkg::ID_W-1:0]       neuron_index,
  input  logic signed [snstep_pkg::Q_W-1:0] input_current,
  input  logic                              first_step,
  input  snstep_pkg::cfg_t                  cfg,
  output snstep_pkg::core_status_t          status,
  output logic                              push,
  output snstep_pkg::res_t                  result
);
  import snstep_pkg::*;

  localparam int AW     = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int PROD_W = 49;
  localparam int LIN_W  = 40;
  localparam int RND_W  = PROD_W - 16;
  localparam int SUM_W  = 35;
  localparam int VU_W   = 26;

  localparam logic signed [15:0]      A2     = 16'(COEF_A2);
  localparam logic signed [15:0]      A3     = 16'(COEF_A3);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(Q_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(Q_MIN);
  localparam q_t                      Q_HI   = Q_W'(Q_MAX);
  localparam q_t                      Q_LO   = Q_W'(Q_MIN);

  function automatic q_t sat_q(input logic signed [SUM_W-1:0] x);
    q_t r;
    if (x > SAT_HI) begin
      r = Q_HI;
    end else if (x < SAT_LO) begin
      r = Q_LO;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

  logic [AW-1:0] addr_lut [ID_COUNT];
  for (genvar g = 0; g < ID_COUNT; g++) begin : g_addr
    assign addr_lut[g] = AW'(g % NEURONS);
  end

  q_t membrane [NEURONS];
  q_t recovery [NEURONS];
  q_t rd_v;
  q_t rd_u;

  logic [AW-1:0] req_addr;

  logic            valid1;
  logic [AW-1:0]   addr1;
  logic [ID_W-1:0] id1;
  q_t              cur1;
  logic            first1;

  logic                     valid2;
  logic [AW-1:0]            addr2;
  logic [ID_W-1:0]          id2;
  q_t                       cur2;
  q_t                       v2;
  q_t                       u2;
  logic                     spike2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [LIN_W-1:0]  a2v2;
  logic signed [LIN_W-1:0]  a3u2;

  logic            valid3;
  logic [AW-1:0]   addr3;
  logic [ID_W-1:0] id3;
  q_t              nv3;
  q_t              u3;
  logic            spike3;

  q_t                       v1;
  q_t                       u1;
  q_t                       th_s;
  logic signed [Q_W:0]      mul_op;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [LIN_W-1:0]  a2v_next;
  logic signed [LIN_W-1:0]  a3u_next;
  logic                     spike_next;

  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  izh_sum;
  logic signed [SUM_W-1:0]  lif_sum;
  q_t                       nv_next;

  logic signed [VU_W-1:0] sum_vu;
  logic signed [VU_W-1:0] decay;
  q_t                     nu;

  assign req_addr = addr_lut[neuron_index];

  assign status.hazard = !first_step &&
                         ((valid1 && (addr1 == req_addr)) || (valid2 && (addr2 == req_addr)));
  assign status.inflight = 2'(valid1) + 2'(valid2) + 2'(valid3);

  // The read register takes the value being written back in the same cycle.
  always_ff @(posedge clk) begin
    if (valid3) begin
      membrane[addr3] <= nv3;
      recovery[addr3] <= nu;
    end
    if (valid3 && (addr3 == req_addr)) begin
      rd_v <= nv3;
      rd_u <= nu;
    end else begin
      rd_v <= membrane[req_addr];
      rd_u <= recovery[req_addr];
    end
  end

  assign v1         = first1 ? '0 : rd_v;
  assign u1         = first1 ? '0 : rd_u;
  assign th_s       = {1'b0, cfg.threshold};
  assign mul_op     = (cfg.kind == KIND_LIF) ? {9'b0, cfg.leak_factor} : {v1[Q_W-1], v1};
  assign prod_next  = v1 * mul_op;
  assign a2v_next   = v1 * A2;
  assign a3u_next   = u1 * A3;
  assign spike_next = (cfg.kind == KIND_LIF) ? (v1 > th_s) : (v1 >= th_s);

  assign acc     = (cfg.kind == KIND_LIF) ? prod2
                                          : prod2 + PROD_W'(a2v2) + PROD_W'(a3u2);
  assign acc_r   = acc + PROD_W'(32768);
  assign rnd     = $signed(acc_r[PROD_W-1:16]);
  assign izh_sum = SUM_W'(v2) + SUM_W'(cur2) + SUM_W'(rnd);
  assign lif_sum = SUM_W'(cur2) + SUM_W'(rnd) - (spike2 ? SUM_W'(th_s) : SUM_W'(0));
  assign nv_next = (cfg.kind == KIND_LIF) ? sat_q(lif_sum)
                 : (spike2 ? cfg.reset_potential : sat_q(izh_sum));

  // Rounding of -(nv + u) / 32 reduces to a shift of 16 - (nv + u).
  assign sum_vu = VU_W'(nv3) + VU_W'(u3);
  assign decay  = (VU_W'(16) - sum_vu) >>> 5;
  assign nu     = (cfg.kind == KIND_LIF) ? u3
                : (spike3 ? sat_q(SUM_W'(u3) + SUM_W'(cfg.recovery_jump))
                          : sat_q(SUM_W'(u3) + SUM_W'(decay)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr1  <= req_addr;
      id1    <= neuron_index;
      cur1   <= input_current;
      first1 <= first_step;
    end
    addr2  <= addr1;
    id2    <= id1;
    cur2   <= cur1;
    v2     <= v1;
    u2     <= u1;
    spike2 <= spike_next;
    prod2  <= prod_next;
    a2v2   <= a2v_next;
    a3u2   <= a3u_next;
    addr3  <= addr2;
    id3    <= id2;
    nv3    <= nv_next;
    u3     <= u2;
    spike3 <= spike2;
  end

  assign push             = valid3;
  assign result.spike     = spike3;
  assign result.neuron_id = id3;

endmodule

### rtl/snstep_result_fifo.sv
// ----------------------------------------------------------------------------
// Spiking neuron step result queue
// Holds finished results until the receiver takes them.
// ----------------------------------------------------------------------------
module snstep_result_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  snstep_pkg::res_t              push_data,
  snstep_out_if.source                  response,
  output logic [snstep_pkg::FIFO_AW:0]  count
);
  import snstep_pkg::*;

  res_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign response.valid     = (count != '0);
  assign response.spike     = entries[rd_ptr].spike;
  assign response.neuron_id = entries[rd_ptr].neuron_id;
  assign pop                = response.valid && response.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/spiking_neuron_step.sv
// ----------------------------------------------------------------------------
// Spiking neuron step
// Izhikevich or leaky integrate-and-fire update for a bank of neurons.
// ----------------------------------------------------------------------------
// The request channel takes one item per neuron time step: a neuron index, the
// input current and a first-step flag that starts the neuron from zero. The
// response channel returns one item per request, in order, with the spike
// flag and the neuron index. Registers must be written through the cfg
// channel only while no items are in flight; the block does not enforce it.
// An accepted item passes the pipeline stages and the result queue before
// its result is offered. Items for different neurons are taken one per
// cycle while the result queue has room. An item for a neuron that is still
// in the first two pipeline stages waits, because of the loop through the
// squaring multiplier and the state memory write-back. First-step items
// never wait on an earlier step of their neuron.
// An eight-entry result queue lets the pipeline run while the receiver
// stalls; requests are held off once queued and in-flight items fill it.
// Reset clears the registers to their defaults and empties the pipeline and
// the queue; the state memories are not cleared.
// ----------------------------------------------------------------------------
module spiking_neuron_step #(
  parameter int NEURONS = 256
) (
  input logic          clk,
  input logic          rst,
  snstep_in_if.sink    request,
  snstep_out_if.source response,
  snstep_cfg_if.sink   cfg
);
  import snstep_pkg::*;

  localparam int CNT_W = FIFO_AW + 2;

  cfg_t               regs;
  core_status_t       status;
  logic               accept;
  logic               push;
  res_t               result;
  logic [FIFO_AW:0]   fifo_count;
  logic [CNT_W-1:0]   total;
  logic               pop;

  assign total = CNT_W'(fifo_count) + CNT_W'(status.inflight);
  assign request.ready = !rst && !status.hazard && (total < CNT_W'(FIFO_DEPTH));
  assign accept = request.valid && request.ready;
  assign pop = response.valid && response.ready;

  snstep_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  snstep_core #(
    .NEURONS (NEURONS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .neuron_index  (request.neuron_index),
    .input_current (request.input_current),
    .first_step    (request.first_step),
    .cfg           (regs),
    .status        (status),
    .push          (push),
    .result        (result)
  );

  snstep_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .response  (response),
    .count     (fifo_count)
  );

`include "spiking_neuron_step_assert.svh"

  `SNSTEP_ASSERT_IMP(a_credit_bound, clk, rst, 1'b1, total <= CNT_W'(FIFO_DEPTH))
  `SNSTEP_ASSERT_IMP(a_result_latency, clk, rst, accept, ##3 push)
  `SNSTEP_ASSERT_NEXT(a_count_hold, clk, rst, !push && !pop, $stable(fifo_count))

endmodule

### verif/spiking_neuron_step_tb.sv
// ----------------------------------------------------------------------------
// Spiking neuron step testbench
// Drives neuron update items and register writes into the block. Every item
// is also applied to a local model of both neuron kinds, and each result
// the block returns is compared with the oldest predicted spike flag and id.
// Both channels idle at random, and one long receiver hold-off fills the
// block until it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spiking_neuron_step_tb;
  import snstep_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 85;

  localparam longint RECOVERY_SLOPE = -2048;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;

  localparam cfg_t CFG_DEFAULTS = '{
    kind:            KIND_IZHIKEVICH,
    threshold:       TH_W'(RST_THRESHOLD),
    reset_potential: q_t'(RST_RESET_POT),
    recovery_jump:   q_t'(RST_JUMP),
    leak_factor:     BETA_W'(RST_LEAK)
  };

  logic clk;
  logic rst;

  snstep_in_if  req_ch ();
  snstep_out_if rsp_ch ();
  snstep_cfg_if cfg_ch ();

  spiking_neuron_step #(
    .NEURONS(ID_COUNT)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch),
    .cfg      (cfg_ch)
  );

  cfg_t model_cfg = CFG_DEFAULTS;
  q_t   membrane_mem [ID_COUNT];
  q_t   recovery_mem [ID_COUNT];
  res_t spike_forecast [$];
  bit   primed [ID_COUNT];
  int   errors;
  bit   steady;
  bit   hold_request;
  bit   hold_on;
  int   sink_wait;
  int   cycle_count;

  always #1 clk = ~clk;

  function automatic q_t sat_q(longint x);
    if (x > longint'(Q_MAX)) return q_t'(Q_MAX);
    if (x < longint'(Q_MIN)) return q_t'(Q_MIN);
    return q_t'(x);
  endfunction

  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic res_t advance_neuron(logic [ID_W-1:0] idx, q_t cur, logic first);
    longint v, u, thr, nv, nu;
    logic   fired;
    res_t   r;
    thr = longint'(model_cfg.threshold);
    v = first ? 64'sd0 : longint'(membrane_mem[idx]);
    u = first ? 64'sd0 : longint'(recovery_mem[idx]);
    if (model_cfg.kind == KIND_IZHIKEVICH) begin
      fired = (v >= thr);
      if (fired) begin
        nv = longint'($signed(model_cfg.reset_potential));
        nu = sat_q(u + longint'($signed(model_cfg.recovery_jump)));
      end else begin
        nv = sat_q(v + longint'(cur) + round_q16(v * v + longint'(COEF_A2) * v
                                                 + longint'(COEF_A3) * u));
        nu = sat_q(u + round_q16(RECOVERY_SLOPE * nv + RECOVERY_SLOPE * u));
      end
    end else begin
      fired = (v > thr);
      nv = sat_q(longint'(cur) + round_q16(v * longint'(model_cfg.leak_factor))
                 - (fired ? thr : 64'sd0));
      nu = u;
    end
    membrane_mem[idx] = q_t'(nv);
    recovery_mem[idx] = q_t'(nu);
    r.spike = fired;
    r.neuron_id = idx;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic q_t small_current();
    return q_t'(int'($urandom_range(0, 24000)) - 4000);
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      model_cfg = CFG_DEFAULTS;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_NEURON_KIND:     model_cfg.kind = cfg_ch.data[0];
          CFG_FIRE_THRESHOLD:  model_cfg.threshold = cfg_ch.data[TH_W-1:0];
          CFG_RESET_POTENTIAL: model_cfg.reset_potential = cfg_ch.data;
          CFG_RECOVERY_JUMP:   model_cfg.recovery_jump = cfg_ch.data;
          CFG_LEAK_FACTOR:     model_cfg.leak_factor = cfg_ch.data[BETA_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        spike_forecast.push_back(advance_neuron(req_ch.neuron_index, req_ch.input_current,
                                                req_ch.first_step));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (spike_forecast.size() == 0) begin
          $display("%0t: unexpected item: expected none, got spike %0b id %0d",
                   $time, rsp_ch.spike, rsp_ch.neuron_id);
          errors++;
        end else begin
          want = spike_forecast.pop_front();
          if (rsp_ch.spike !== want.spike) begin
            $display("%0t: spike mismatch on neuron %0d: expected %0b, got %0b",
                     $time, want.neuron_id, want.spike, rsp_ch.spike);
            errors++;
          end
          if (rsp_ch.neuron_id !== want.neuron_id) begin
            $display("%0t: neuron id mismatch: expected %0d, got %0d",
                     $time, want.neuron_id, rsp_ch.neuron_id);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_on) begin
      rsp_ch.ready <= 1'b0;
    end else if (steady) begin
      rsp_ch.ready <= 1'b1;
    end else if (sink_wait > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_wait--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_wait = gap_len();
    end
  end

  always begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(logic [ID_W-1:0] idx, q_t cur, logic first);
    int   gap;
    logic start;
    start = first || !primed[idx];
    primed[idx] = 1'b1;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.neuron_index <= idx;
    req_ch.input_current <= cur;
    req_ch.first_step <= start;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (spike_forecast.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_registers(logic kind, int th, int rp, int jump, int leak);
    wait_idle();
    write_reg(CFG_NEURON_KIND, Q_W'(kind));
    write_reg(CFG_FIRE_THRESHOLD, Q_W'(th));
    write_reg(CFG_RESET_POTENTIAL, Q_W'(rp));
    write_reg(CFG_RECOVERY_JUMP, Q_W'(jump));
    write_reg(CFG_LEAK_FACTOR, Q_W'(leak));
  endtask

  task automatic test_reset_defaults();
    send_item(8'd0, q_t'(Q_MAX), 1'b1);
    send_item(8'd0, q_t'(0), 1'b0);
    send_item(8'd0, q_t'(0), 1'b0);
    send_item(8'd255, q_t'(Q_MIN), 1'b1);
    send_item(8'd255, q_t'(0), 1'b0);
    send_item(8'd1, q_t'(0), 1'b1);
    send_item(8'd1, q_t'(13107), 1'b0);
  endtask

  // Writes to spare indexes must change nothing, and wide data is cut to
  // the width of each register.
  task automatic test_register_masking();
    wait_idle();
    for (int i = CFG_SPARE_LO; i < 2 ** CFG_IDX_W; i++) write_reg(CFG_IDX_W'(i), '1);
    write_reg(CFG_NEURON_KIND, 24'hFFFFFE);
    write_reg(CFG_FIRE_THRESHOLD, 24'hFFFFFF);
    write_reg(CFG_LEAK_FACTOR, 24'hFF0000);
    send_item(8'd2, q_t'(Q_MAX), 1'b1);
    send_item(8'd2, q_t'(0), 1'b0);
    send_item(8'd3, q_t'(0), 1'b1);
  endtask

  task automatic test_register_extremes();
    set_registers(KIND_IZHIKEVICH, 0, Q_MIN, Q_MAX, 0);
    send_item(8'd20, q_t'(0), 1'b1);
    send_item(8'd20, q_t'(0), 1'b0);
    set_registers(KIND_IZHIKEVICH, Q_MAX, Q_MAX, Q_MIN, 65535);
    send_item(8'd21, q_t'(Q_MAX), 1'b1);
    send_item(8'd21, q_t'(0), 1'b0);
    set_registers(KIND_LIF, 0, RST_RESET_POT, RST_JUMP, 0);
    send_item(8'd22, q_t'(Q_MAX), 1'b1);
    send_item(8'd22, q_t'(Q_MIN), 1'b0);
    set_registers(KIND_LIF, Q_MAX, RST_RESET_POT, RST_JUMP, 65535);
    send_item(8'd23, q_t'(Q_MAX), 1'b1);
    send_item(8'd23, q_t'(Q_MAX), 1'b0);
    send_item(8'd23, q_t'(0), 1'b0);
  endtask

  // A first step in LIF mode clears the recovery value, which shows once the
  // same neuron runs on in Izhikevich mode.
  task automatic test_lif_first_step();
    set_registers(KIND_IZHIKEVICH, RST_THRESHOLD, RST_RESET_POT, RST_JUMP, RST_LEAK);
    send_item(8'd7, q_t'(Q_MAX), 1'b1);
    send_item(8'd7, q_t'(0), 1'b0);
    set_registers(KIND_LIF, RST_THRESHOLD, RST_RESET_POT, RST_JUMP, RST_LEAK);
    send_item(8'd7, q_t'(1000), 1'b1);
    set_registers(KIND_IZHIKEVICH, RST_THRESHOLD, RST_RESET_POT, RST_JUMP, RST_LEAK);
    send_item(8'd7, q_t'(30000), 1'b0);
    send_item(8'd7, q_t'(30000), 1'b0);
  endtask

  // Mostly runs of steps on one or two neurons with modest currents, so that
  // membranes build up and fire; the rest are items with arbitrary fields.
  task automatic run_sequences(int count);
    int sent;
    int len;
    logic [ID_W-1:0] lead, other;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(ID_W'($urandom), q_t'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        lead = ID_W'($urandom);
        other = ID_W'($urandom);
        len = $urandom_range(3, 14);
        send_item(lead, small_current(), 1'($urandom_range(0, 1)));
        for (int k = 1; k < len; k++) begin
          send_item(($urandom_range(0, 2) == 0) ? other : lead, small_current(),
                    $urandom_range(0, 24) == 0);
        end
        sent += len;
      end
    end
  endtask

  task automatic test_random_steps();
    logic kind;
    int th, rp, jump, leak;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p % 2 == 0) ? KIND_IZHIKEVICH : KIND_LIF;
      if (p == 0) begin
        th = RST_THRESHOLD;
        rp = RST_RESET_POT;
        jump = RST_JUMP;
        leak = RST_LEAK;
      end else if (p == 4 || p == 5) begin
        th = $urandom;
        rp = $urandom;
        jump = $urandom;
        leak = $urandom;
      end else begin
        th = $urandom_range(20000, 70000);
        rp = $urandom_range(0, 20000);
        jump = $urandom_range(0, 40000);
        leak = $urandom_range(50000, 65535);
      end
      set_registers(kind, th, rp, jump, leak);
      steady = (p == 3);
      run_sequences(PHASE_ITEMS);
      steady = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    steady = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 48; i++) send_item(ID_W'(i * 5), small_current(), 1'b0);
    steady = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.neuron_index = '0;
    req_ch.input_current = '0;
    req_ch.first_step = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_masking();
    test_register_extremes();
    test_lif_first_step();
    test_random_steps();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/snstep_pkg.sv
rtl/snstep_in_if.sv
rtl/snstep_out_if.sv
rtl/snstep_cfg_if.sv
rtl/snstep_cfg_regs.sv
rtl/snstep_core.sv
rtl/snstep_result_fifo.sv
rtl/spiking_neuron_step.sv
verif/spiking_neuron_step_tb.sv
